// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define REBE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define REBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define REBE_ASSERT_ALWAYS(lbl, prop)
`define REBE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/rebe_pkg.sv =====
// ----------------------------------------------------------------------------
// rebe_pkg
// codes, reset values and types for the encoder and button event block
// ----------------------------------------------------------------------------
`default_nettype none

package rebe_pkg;

  localparam int TIME_W  = 32;
  localparam int LIMIT_W = 16;
  localparam int EVENT_W = 3;
  localparam int OP_W    = 2;
  localparam int STEP_W  = 4;
  localparam int CFG_IDX_W = 2;

  // item operations
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_FETCH  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EVENT_W-1:0] EV_RIGHT  = 3'd1;
  localparam logic [EVENT_W-1:0] EV_LEFT   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_SHORT  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_MEDIUM = 3'd4;
  localparam logic [EVENT_W-1:0] EV_LONG   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_REV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 2'd3;

  localparam logic [LIMIT_W-1:0] SHORT_RST  = 16'd30;
  localparam logic [LIMIT_W-1:0] MEDIUM_RST = 16'd600;
  localparam logic [LIMIT_W-1:0] LONG_RST   = 16'd1500;

  // quadrature states, a*2 + b
  localparam logic [1:0] QUAD_00 = 2'b00;
  localparam logic [1:0] QUAD_01 = 2'b01;
  localparam logic [1:0] QUAD_11 = 2'b11;
  localparam logic [1:0] QUAD_10 = 2'b10;

  localparam logic signed [STEP_W-1:0] STEP_POS_LIM = 4'sd4;
  localparam logic signed [STEP_W-1:0] STEP_NEG_LIM = -4'sd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [1:0]        quad;
    logic              down;
    logic [TIME_W-1:0] now_ms;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/rotary_encoder_button_events.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_button_events: quadrature decoder and button press classifier
// path: input reg, then result reg; a result waits in the result reg until taken
// throughput: one item per cycle while the result register is free or being emptied
// reset: synchronous rst_n clears state, config returns to 0/30/600/1500
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rotary_encoder_button_events (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [rebe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rebe_pkg::LIMIT_W-1:0]  cfg_wdata,
  // input items
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [rebe_pkg::OP_W-1:0]     in_op,
  input  wire logic                          in_pin_a,
  input  wire logic                          in_pin_b,
  input  wire logic                          in_button_down,
  input  wire logic [rebe_pkg::TIME_W-1:0]   in_now_ms,
  // result items
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [rebe_pkg::EVENT_W-1:0]  out_event_res
);
  import rebe_pkg::*;

  // configuration registers
  logic               dir_rev_r;
  logic [LIMIT_W-1:0] short_ms_r;
  logic [LIMIT_W-1:0] medium_ms_r;
  logic [LIMIT_W-1:0] long_ms_r;

  // input register stage
  item_t s1_item_r;
  logic  s1_valid_r;

  // decoder and button state
  logic [1:0]               last_quad_r, last_quad_nxt;
  logic                     primed_r, primed_nxt;
  logic signed [STEP_W-1:0] step_r, step_nxt;
  logic [EVENT_W-1:0]       pend_r, pend_nxt;
  logic                     held_r, held_nxt;
  logic                     long_rep_r, long_rep_nxt;
  logic [TIME_W-1:0]        press_start_r, press_start_nxt;

  // result register
  logic               out_valid_r;
  logic [EVENT_W-1:0] out_event_r;
  logic [EVENT_W-1:0] res_nxt;

  logic                     advance;
  logic                     fwd_step;
  logic signed [STEP_W-1:0] step_sum;
  logic [EVENT_W-1:0]       pend_rot;
  logic [TIME_W-1:0]        held_ms;
  logic                     ge_long, ge_medium, ge_short;

  // the stage moves on whenever the result register is free or being emptied
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  // no item is taken while reset is held
  assign in_ready = rst_n && (!s1_valid_r || advance);

  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;

  // configuration, to be written only while the block is idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_rev_r   <= 1'b0;
      short_ms_r  <= SHORT_RST;
      medium_ms_r <= MEDIUM_RST;
      long_ms_r   <= LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIR_REV: dir_rev_r   <= cfg_wdata[0];
        CFG_SHORT:   short_ms_r  <= cfg_wdata;
        CFG_MEDIUM:  medium_ms_r <= cfg_wdata;
        CFG_LONG:    long_ms_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register: takes a new item whenever the stage is empty or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r.op     <= in_op;
      s1_item_r.quad   <= {in_pin_a, in_pin_b};
      s1_item_r.down   <= in_button_down;
      s1_item_r.now_ms <= in_now_ms;
    end
  end

  // forward gray sequence 00 -> 01 -> 11 -> 10 -> 00
  assign fwd_step = (last_quad_r == QUAD_00 && s1_item_r.quad == QUAD_01) ||
                    (last_quad_r == QUAD_01 && s1_item_r.quad == QUAD_11) ||
                    (last_quad_r == QUAD_11 && s1_item_r.quad == QUAD_10) ||
                    (last_quad_r == QUAD_10 && s1_item_r.quad == QUAD_00);

  assign step_sum = fwd_step ? (step_r + 4'sd1) : (step_r - 4'sd1);

  // held time wraps modulo 2^32, limits are zero-extended
  assign held_ms   = s1_item_r.now_ms - press_start_r;
  assign ge_long   = held_ms >= {{(TIME_W-LIMIT_W){1'b0}}, long_ms_r};
  assign ge_medium = held_ms >= {{(TIME_W-LIMIT_W){1'b0}}, medium_ms_r};
  assign ge_short  = held_ms >= {{(TIME_W-LIMIT_W){1'b0}}, short_ms_r};

  always_comb begin
    last_quad_nxt   = last_quad_r;
    primed_nxt      = primed_r;
    step_nxt        = step_r;
    pend_rot        = pend_r;
    pend_nxt        = pend_r;
    held_nxt        = held_r;
    long_rep_nxt    = long_rep_r;
    press_start_nxt = press_start_r;
    res_nxt         = pend_r;

    case (s1_item_r.op)
      OP_SAMPLE: begin
        // rotation: first sample only primes the pin state
        if (!primed_r) begin
          last_quad_nxt = s1_item_r.quad;
          primed_nxt    = 1'b1;
        end else if (s1_item_r.quad != last_quad_r) begin
          last_quad_nxt = s1_item_r.quad;
          if (step_sum == STEP_POS_LIM) begin
            step_nxt = '0;
            if (pend_r == EV_NONE) begin
              pend_rot = dir_rev_r ? EV_LEFT : EV_RIGHT;
            end
          end else if (step_sum == STEP_NEG_LIM) begin
            step_nxt = '0;
            if (pend_r == EV_NONE) begin
              pend_rot = dir_rev_r ? EV_RIGHT : EV_LEFT;
            end
          end else begin
            step_nxt = step_sum;
          end
        end

        pend_nxt = pend_rot;

        // button: press edge, long while held, classify on release
        if (s1_item_r.down && !held_r) begin
          held_nxt        = 1'b1;
          long_rep_nxt    = 1'b0;
          press_start_nxt = s1_item_r.now_ms;
        end else if (s1_item_r.down && !long_rep_r) begin
          if (ge_long) begin
            pend_nxt     = EV_LONG;
            long_rep_nxt = 1'b1;
          end
        end else if (!s1_item_r.down && held_r) begin
          if (!long_rep_r && pend_rot == EV_NONE) begin
            if (ge_medium) begin
              pend_nxt = EV_MEDIUM;
            end else if (ge_short) begin
              pend_nxt = EV_SHORT;
            end
          end
          held_nxt     = 1'b0;
          long_rep_nxt = 1'b0;
        end

        res_nxt = pend_nxt;
      end
      OP_FETCH: begin
        res_nxt  = pend_r;
        pend_nxt = EV_NONE;
      end
      OP_CLEAR: begin
        res_nxt  = EV_NONE;
        pend_nxt = EV_NONE;
      end
      default: begin
        // unused op leaves everything alone
        res_nxt = pend_r;
      end
    endcase
  end

  // state commits once per item as it leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_quad_r   <= QUAD_00;
      primed_r      <= 1'b0;
      step_r        <= '0;
      pend_r        <= EV_NONE;
      held_r        <= 1'b0;
      long_rep_r    <= 1'b0;
      press_start_r <= '0;
    end else if (advance) begin
      last_quad_r   <= last_quad_nxt;
      primed_r      <= primed_nxt;
      step_r        <= step_nxt;
      pend_r        <= pend_nxt;
      held_r        <= held_nxt;
      long_rep_r    <= long_rep_nxt;
      press_start_r <= press_start_nxt;
    end
  end

  // result register, holds until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_r <= res_nxt;
    end
  end

  // step counter always folds back inside -3..+3 between items
  `REBE_ASSERT_ALWAYS(a_step_range, (step_r <= 4'sd3) && (step_r >= -4'sd3))
  // pending event is always a defined code
  `REBE_ASSERT_ALWAYS(a_pend_code, pend_r <= EV_LONG)
  // a long press can only be marked while the button is held
  `REBE_ASSERT_ALWAYS(a_long_held, !long_rep_r || held_r)
  // a clear item always reports no event and leaves none pending
  `REBE_ASSERT_NEXT(a_clear_res, advance && (s1_item_r.op == OP_CLEAR),
                    (out_event_r == EV_NONE) && (pend_r == EV_NONE))

endmodule

`default_nettype wire

// ===== test/rotary_encoder_button_events_tb.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_button_events_tb
// drives sample, fetch and clear items into the encoder and button event
// block, predicts every event_res in step with the accepted items and checks
// each result in order, across several limit settings and idling phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_encoder_button_events_tb;
  import rebe_pkg::*;

  // op value that the block leaves alone
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 200000;
  // quiet cycles after the last owed result
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  // block inputs, all known from time zero
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = CFG_DIR_REV;
  logic [LIMIT_W-1:0]   cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic [OP_W-1:0]      in_op          = OP_SAMPLE;
  logic                 in_pin_a       = 1'b0;
  logic                 in_pin_b       = 1'b0;
  logic                 in_button_down = 1'b0;
  logic [TIME_W-1:0]    in_now_ms      = '0;
  logic                 out_ready      = 1'b0;

  logic                 in_ready;
  logic                 out_valid;
  logic [EVENT_W-1:0]   out_event_res;

  rotary_encoder_button_events dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_pin_a       (in_pin_a),
    .in_pin_b       (in_pin_b),
    .in_button_down (in_button_down),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_res  (out_event_res)
  );

  // predicted block state, reset values
  logic                     lim_dir_rev   = 1'b0;
  logic [LIMIT_W-1:0]       lim_short     = SHORT_RST;
  logic [LIMIT_W-1:0]       lim_medium    = MEDIUM_RST;
  logic [LIMIT_W-1:0]       lim_long      = LONG_RST;
  logic [1:0]               enc_quad      = QUAD_00;
  logic                     enc_primed    = 1'b0;
  logic signed [STEP_W-1:0] enc_steps     = '0;
  logic [EVENT_W-1:0]       ev_pending    = EV_NONE;
  logic                     btn_held      = 1'b0;
  logic                     btn_long_done = 1'b0;
  logic [TIME_W-1:0]        btn_press_ms  = '0;

  // event_res values still owed by the block, oldest first
  logic [EVENT_W-1:0] event_res_due[$];

  // idling knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off: requests are counted by the tests, the ready
  // process takes each new one and counts the stretch down itself
  int hold_req       = 0;
  int hold_taken     = 0;
  int ready_hold     = 0;

  int cycle_count     = 0;
  int mismatches      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int fetched[8];

  // stimulus generator state: where the knob is, time, button
  logic [1:0]        gen_quad = QUAD_11;
  logic              gen_fwd  = 1'b1;
  logic              gen_down = 1'b0;
  logic [TIME_W-1:0] gen_now  = 32'h0001_0000;

  // next event_res for one accepted item, advancing the predicted state
  function automatic logic [EVENT_W-1:0] next_event_res(
    input logic [OP_W-1:0]   op,
    input logic [1:0]        quad,
    input logic              down,
    input logic [TIME_W-1:0] now
  );
    logic              fwd;
    logic [TIME_W-1:0] held_ms;
    logic [EVENT_W-1:0] res;
    res = ev_pending;
    case (op)
      OP_SAMPLE: begin
        // first sample only latches the pins
        if (!enc_primed) begin
          enc_quad   = quad;
          enc_primed = 1'b1;
        end else if (quad != enc_quad) begin
          fwd = (enc_quad == QUAD_00 && quad == QUAD_01) ||
                (enc_quad == QUAD_01 && quad == QUAD_11) ||
                (enc_quad == QUAD_11 && quad == QUAD_10) ||
                (enc_quad == QUAD_10 && quad == QUAD_00);
          enc_steps = fwd ? enc_steps + 4'sd1 : enc_steps - 4'sd1;
          if (enc_steps == STEP_POS_LIM) begin
            if (ev_pending == EV_NONE) ev_pending = lim_dir_rev ? EV_LEFT : EV_RIGHT;
            enc_steps = '0;
          end else if (enc_steps == STEP_NEG_LIM) begin
            if (ev_pending == EV_NONE) ev_pending = lim_dir_rev ? EV_RIGHT : EV_LEFT;
            enc_steps = '0;
          end
          enc_quad = quad;
        end
        // button timing, wrapping subtraction
        held_ms = now - btn_press_ms;
        if (down && !btn_held) begin
          btn_held      = 1'b1;
          btn_long_done = 1'b0;
          btn_press_ms  = now;
        end else if (down && btn_held && !btn_long_done) begin
          if (held_ms >= {16'd0, lim_long}) begin
            ev_pending    = EV_LONG;
            btn_long_done = 1'b1;
          end
        end else if (!down && btn_held) begin
          if (!btn_long_done && ev_pending == EV_NONE) begin
            if (held_ms >= {16'd0, lim_medium}) ev_pending = EV_MEDIUM;
            else if (held_ms >= {16'd0, lim_short}) ev_pending = EV_SHORT;
          end
          btn_held      = 1'b0;
          btn_long_done = 1'b0;
        end
        res = ev_pending;
      end
      OP_FETCH: begin
        res = ev_pending;
        fetched[res]++;
        ev_pending = EV_NONE;
      end
      OP_CLEAR: begin
        ev_pending = EV_NONE;
        res = EV_NONE;
      end
      default: res = ev_pending;
    endcase
    return res;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, event_res_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, or a solid hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_taken) begin
      out_ready  <= 1'b0;
      ready_hold <= HOLD_CYCLES - 1;
      hold_taken <= hold_req;
    end else if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker, values sampled at the edge
  always @(posedge clk) begin
    logic [EVENT_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (event_res_due.size() == 0) begin
        $error("event_res: result with no item outstanding, got %0d", out_event_res);
        mismatches++;
      end else begin
        want = event_res_due.pop_front();
        results_checked++;
        if (out_event_res !== want) begin
          $error("event_res: expected %0d, got %0d", want, out_event_res);
          mismatches++;
        end
      end
    end
  end

  // offer one item, wait for the handshake, then book its expected result
  task automatic send_item(
    input logic [OP_W-1:0]   op,
    input logic              pin_a,
    input logic              pin_b,
    input logic              down,
    input logic [TIME_W-1:0] now
  );
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_pin_a       <= pin_a;
    in_pin_b       <= pin_b;
    in_button_down <= down;
    in_now_ms      <= now;
    do @(posedge clk); while (!in_ready);
    event_res_due.push_back(next_event_res(op, {pin_a, pin_b}, down, now));
    items_sent++;
  endtask

  // stop offering and let every owed result come out
  task automatic wait_drained;
    in_valid <= 1'b0;
    while (event_res_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back, block idle
  task automatic load_limits(
    input logic               dir_rev,
    input logic [LIMIT_W-1:0] short_ms,
    input logic [LIMIT_W-1:0] medium_ms,
    input logic [LIMIT_W-1:0] long_ms
  );
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIR_REV;
    // upper bits of the direction write are don't care
    cfg_wdata <= {15'($urandom()), dir_rev};
    @(posedge clk);
    cfg_index <= CFG_SHORT;
    cfg_wdata <= short_ms;
    @(posedge clk);
    cfg_index <= CFG_MEDIUM;
    cfg_wdata <= medium_ms;
    @(posedge clk);
    cfg_index <= CFG_LONG;
    cfg_wdata <= long_ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    lim_dir_rev = dir_rev;
    lim_short   = short_ms;
    lim_medium  = medium_ms;
    lim_long    = long_ms;
  endtask

  // mostly a knob being turned and a button being pressed, some pin noise,
  // with fetches and clears mixed in; unused ops are not counted
  task automatic random_traffic(input int count);
    int                counted;
    int                pick;
    logic [TIME_W-1:0] step_ms;
    counted = 0;
    while (counted < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(9) == 0) gen_fwd = !gen_fwd;
        pick = $urandom_range(99);
        if (pick < 75) begin
          // one clean gray step in the current direction
          case (gen_quad)
            QUAD_00: gen_quad = gen_fwd ? QUAD_01 : QUAD_10;
            QUAD_01: gen_quad = gen_fwd ? QUAD_11 : QUAD_00;
            QUAD_11: gen_quad = gen_fwd ? QUAD_10 : QUAD_01;
            default: gen_quad = gen_fwd ? QUAD_00 : QUAD_11;
          endcase
        end else if (pick >= 85) begin
          // bounce or skipped state
          gen_quad = 2'($urandom());
        end
        if ($urandom_range(99) < 12) gen_down = !gen_down;
        // time steps straddle the press limits, now and then a huge jump
        pick = $urandom_range(99);
        if (pick < 40) step_ms = $urandom_range(40);
        else if (pick < 75) step_ms = $urandom_range(400);
        else if (pick < 95) step_ms = $urandom_range(2000);
        else step_ms = $urandom();
        gen_now = gen_now + step_ms;
        send_item(OP_SAMPLE, gen_quad[1], gen_quad[0], gen_down, gen_now);
        counted++;
      end else if (pick < 85) begin
        send_item(OP_FETCH, 1'($urandom()), 1'($urandom()), 1'($urandom()), $urandom());
        counted++;
      end else if (pick < 95) begin
        send_item(OP_CLEAR, 1'($urandom()), 1'($urandom()), 1'($urandom()), $urandom());
        counted++;
      end else begin
        send_item(OP_UNUSED, 1'($urandom()), 1'($urandom()), 1'($urandom()), $urandom());
      end
    end
  endtask

  // reset limits: priming, both rotations, unused op, wrap, short and none
  task automatic test_default_limits;
    send_item(OP_FETCH, 1'b0, 1'b0, 1'b0, 32'd0);
    // first sample only primes the pins at 11
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd0);
    // four forward steps give right
    send_item(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 32'd1);
    send_item(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd2);
    send_item(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd3);
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd4);
    send_item(OP_UNUSED, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_FETCH, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // four backward steps give left, press on the last one just before wrap
    send_item(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd6);
    send_item(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd7);
    send_item(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 32'd8);
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0);
    send_item(OP_CLEAR, 1'b0, 1'b0, 1'b0, 32'd0);
    // release across the wrap, held exactly the short limit
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'h0000_000E);
    send_item(OP_FETCH, 1'b0, 1'b0, 1'b0, 32'd0);
    // release one below the short limit posts nothing
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd100);
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd129);
  endtask

  // zero and full-scale limits, reversed direction
  task automatic test_limit_extremes;
    wait_drained();
    load_limits(1'b1, 16'd0, 16'hFFFF, 16'd0);
    // press edge never reports long, even with a zero long limit
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd0);
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd0);
    // release after long posts nothing
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd7);
    send_item(OP_FETCH, 1'b0, 1'b0, 1'b0, 32'd0);
    wait_drained();
    load_limits(1'b0, 16'hFFFF, 16'd0, 16'hFFFF);
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'd5);
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd5);
    // long overwrites the pending medium, held time wraps through zero
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 32'h0000_FFFE);
    send_item(OP_FETCH, 1'b0, 1'b0, 1'b0, 32'd0);
    gen_down = 1'b1;
    gen_now  = 32'h0001_0000;
  endtask

  // receiver holds off while items keep coming, then the sender pauses
  task automatic test_receiver_hold_off;
    wait_drained();
    load_limits(1'($urandom()), 16'd30, 16'd600, 16'd1500);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    random_traffic(40);
    wait_drained();
    random_traffic(10);
  endtask

  // random traffic in four idling phases, fresh limits each time
  task automatic test_random_phases;
    int idle_plan[4];
    int stall_plan[4];
    idle_plan  = '{0, 51, 0, 22};
    stall_plan = '{0, 0, 51, 22};
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      load_limits(1'($urandom()), 16'($urandom_range(100)),
                  16'($urandom_range(900)), 16'($urandom_range(3000)));
      send_idle_pct  = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      random_traffic(250);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_default_limits();
    test_limit_extremes();
    test_receiver_hold_off();
    test_random_phases();

    // everything owed must arrive, then the inputs stay quiet for a drain stretch
    wait_drained();

    $display("%0d items sent, %0d results checked across 4 idling phases and 8 limit sets",
             items_sent, results_checked);
    $display("fetched: right %0d, left %0d, short %0d, medium %0d, long %0d",
             fetched[EV_RIGHT], fetched[EV_LEFT], fetched[EV_SHORT],
             fetched[EV_MEDIUM], fetched[EV_LONG]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
